@@ design/cip_pkg.sv @@
// ----------------------------------------------------------------------------
// cip_pkg
// Shared types, codes and helpers for the checked integer power block.
// ----------------------------------------------------------------------------
package cip_pkg;

   localparam int unsigned DATA_BITS = 64;
   localparam int unsigned PROD_BITS = 2 * DATA_BITS;
   localparam int unsigned HALF_BITS = DATA_BITS / 2;

   // arithmetic mode codes
   localparam logic OP_UNSIGNED = 1'b0;
   localparam logic OP_SIGNED   = 1'b1;

   // request into the shared checked multiplier
   typedef struct packed {
      logic                 start;
      logic                 sgn;
      logic [DATA_BITS-1:0] a;
      logic [DATA_BITS-1:0] b;
   } mul_req_type;

   // response from the shared checked multiplier
   typedef struct packed {
      logic                 done;
      logic                 ovf;
      logic [DATA_BITS-1:0] prod;
   } mul_rsp_type;

   // sign-extend a word-wide pattern held in a 64-bit container
   function automatic logic [DATA_BITS-1:0] sext_word(
      input logic [DATA_BITS-1:0] v,
      input logic [DATA_BITS-1:0] wmask,
      input logic [DATA_BITS-1:0] wsign
   );
      logic [DATA_BITS-1:0] m;
      m = v & wmask;
      return ((m & wsign) != '0) ? (m | ~wmask) : m;
   endfunction

endpackage

@@ design/cip_mul.sv @@
// ----------------------------------------------------------------------------
// cip_mul
// Shared checked multiplier: sign/magnitude split, four 32x32 partial
// products accumulated over cycles, then a range check for the mode.
// ----------------------------------------------------------------------------
module cip_mul #(
   parameter int unsigned WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cip_pkg::mul_req_type req,
   output cip_pkg::mul_rsp_type rsp
);

   localparam logic [cip_pkg::DATA_BITS-1:0] WMASK =
      {cip_pkg::DATA_BITS{1'b1}} >> (cip_pkg::DATA_BITS - WORD_BITS);
   localparam logic [cip_pkg::DATA_BITS-1:0] WSIGN =
      cip_pkg::DATA_BITS'(1) << (WORD_BITS - 1);
   localparam logic [2:0] STEP_LAST = 3'd4;

   typedef enum logic [1:0] {M_IDLE, M_RUN, M_CHECK} mstate_type;

   mstate_type                       state_ff;
   logic [2:0]                       step_ff;
   logic [1:0]                       sel_ff;
   logic                             sgn_ff;
   logic                             neg_ff;
   logic [cip_pkg::DATA_BITS-1:0]    ma_ff;
   logic [cip_pkg::DATA_BITS-1:0]    mb_ff;
   logic [cip_pkg::DATA_BITS-1:0]    pp_ff;
   logic [cip_pkg::PROD_BITS-1:0]    acc_ff;
   logic                             done_ff;
   logic                             ovf_ff;
   logic [cip_pkg::DATA_BITS-1:0]    prod_ff;

   logic                             na, nb;
   logic [cip_pkg::DATA_BITS-1:0]    ma_in, mb_in;
   logic [cip_pkg::HALF_BITS-1:0]    a_half, b_half;
   logic [cip_pkg::PROD_BITS-1:0]    pp_shifted;
   logic [cip_pkg::DATA_BITS-1:0]    lo, limit, mag_signed, prod_in;
   logic                             ovf_in;

   // magnitudes of the operands
   always_comb begin
      na    = req.sgn & req.a[cip_pkg::DATA_BITS-1];
      nb    = req.sgn & req.b[cip_pkg::DATA_BITS-1];
      ma_in = na ? ('0 - req.a) : req.a;
      mb_in = nb ? ('0 - req.b) : req.b;
   end

   // partial product operand select: step bit 1 picks the half of a, bit 0 of b
   assign a_half = step_ff[1] ? ma_ff[cip_pkg::DATA_BITS-1:cip_pkg::HALF_BITS]
                              : ma_ff[cip_pkg::HALF_BITS-1:0];
   assign b_half = step_ff[0] ? mb_ff[cip_pkg::DATA_BITS-1:cip_pkg::HALF_BITS]
                              : mb_ff[cip_pkg::HALF_BITS-1:0];

   always_comb begin
      case (sel_ff) inside
         2'd0:       pp_shifted = {{cip_pkg::DATA_BITS{1'b0}}, pp_ff};
         2'd1, 2'd2: pp_shifted = {{cip_pkg::HALF_BITS{1'b0}}, pp_ff,
                                   {cip_pkg::HALF_BITS{1'b0}}};
         default:    pp_shifted = {pp_ff, {cip_pkg::DATA_BITS{1'b0}}};
      endcase
   end

   // range check and signed result
   always_comb begin
      lo         = acc_ff[cip_pkg::DATA_BITS-1:0];
      limit      = sgn_ff ? (neg_ff ? WSIGN : (WSIGN - 1'b1)) : WMASK;
      ovf_in     = (acc_ff[cip_pkg::PROD_BITS-1:cip_pkg::DATA_BITS] != '0) || (lo > limit);
      mag_signed = neg_ff ? ('0 - lo) : lo;
      prod_in    = sgn_ff ? cip_pkg::sext_word(mag_signed, WMASK, WSIGN) : lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            M_IDLE: begin
               if (req.start) begin
                  sgn_ff   <= req.sgn;
                  neg_ff   <= na ^ nb;
                  ma_ff    <= ma_in;
                  mb_ff    <= mb_in;
                  acc_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= M_RUN;
               end
            end
            M_RUN: begin
               if (!step_ff[2]) begin
                  pp_ff  <= a_half * b_half;
                  sel_ff <= step_ff[1:0];
               end
               if (step_ff != '0) begin
                  acc_ff <= acc_ff + pp_shifted;
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == STEP_LAST) begin
                  state_ff <= M_CHECK;
               end
            end
            M_CHECK: begin
               done_ff  <= 1'b1;
               ovf_ff   <= ovf_in;
               prod_ff  <= prod_in;
               state_ff <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.prod = prod_ff;

endmodule

@@ design/checked_integer_power.sv @@
// ----------------------------------------------------------------------------
// checked_integer_power - overflow-checked base^exponent, square-and-multiply
// Each set exponent bit costs a checked multiply acc * cur, and each bit below
//   the highest set one a squaring cur * cur, all on the one shared multiplier
//   that forms each checked 64x64 multiply from four 32x32 partial products.
// Throughput: one transaction at a time; req_tready is high only when idle.
// Reset: synchronous, active high; clears the sequencer and rsp_tvalid.
// ----------------------------------------------------------------------------
module checked_integer_power #(
   parameter int unsigned WORD_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] base_bits, [127:64] exponent
   input  logic         req_tuser,   // [0] op (0 unsigned, 1 signed)
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // [63:0] power_bits
   output logic         rsp_tuser    // [0] overflow
);

   localparam logic [cip_pkg::DATA_BITS-1:0] WMASK =
      {cip_pkg::DATA_BITS{1'b1}} >> (cip_pkg::DATA_BITS - WORD_BITS);
   localparam logic [cip_pkg::DATA_BITS-1:0] WSIGN =
      cip_pkg::DATA_BITS'(1) << (WORD_BITS - 1);

   // S_STEP   look at the current exponent bit
   // S_ACC    wait for acc * cur
   // S_SHIFT  drop the exponent bit, square if bits remain
   // S_SQ     wait for cur * cur
   // S_FINISH hand the result to the output register
   typedef enum logic [2:0] {S_IDLE, S_STEP, S_ACC, S_SHIFT, S_SQ, S_FINISH} state_type;

   state_type                      state_ff;
   logic                           sgn_ff;
   logic                           ovf_ff;
   logic [cip_pkg::DATA_BITS-1:0]  e_ff;
   logic [cip_pkg::DATA_BITS-1:0]  cur_ff;
   logic [cip_pkg::DATA_BITS-1:0]  acc_ff;
   cip_pkg::mul_req_type           mul_req_ff;
   cip_pkg::mul_rsp_type           mul_rsp;
   logic                           rsp_valid_ff;
   logic [cip_pkg::DATA_BITS-1:0]  rsp_data_ff;
   logic                           rsp_ovf_ff;

   logic                           req_sgn;
   logic [cip_pkg::DATA_BITS-1:0]  base_in;
   logic [cip_pkg::DATA_BITS-1:0]  e_shift;
   logic                           mul_issue;

   // read the base per mode: sign-extend or mask to the word
   assign req_sgn = (req_tuser == cip_pkg::OP_SIGNED);
   assign base_in = req_sgn ? cip_pkg::sext_word(req_tdata[63:0], WMASK, WSIGN)
                            : (req_tdata[63:0] & WMASK);
   assign e_shift = e_ff >> 1;

   // pulse the shared multiplier for acc * cur or for cur * cur
   assign mul_issue = ((state_ff == S_STEP) && (e_ff != '0) && e_ff[0]) ||
                      ((state_ff == S_SHIFT) && (e_shift != '0));

   assign req_tready = (state_ff == S_IDLE);

   cip_mul #(
      .WORD_BITS (WORD_BITS)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req_ff),
      .rsp   (mul_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         mul_req_ff.start <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         mul_req_ff.start <= mul_issue;
         // drop the response once it has been taken; the finish step
         // reloads the output register on its own
         if (rsp_tready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  sgn_ff   <= req_sgn;
                  cur_ff   <= base_in;
                  e_ff     <= req_tdata[127:64];
                  acc_ff   <= cip_pkg::DATA_BITS'(1);
                  ovf_ff   <= 1'b0;
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               if (e_ff == '0) begin
                  state_ff <= S_FINISH;
               end else if (e_ff[0]) begin
                  // multiply the running result by the running square
                  mul_req_ff.sgn   <= sgn_ff;
                  mul_req_ff.a     <= acc_ff;
                  mul_req_ff.b     <= cur_ff;
                  state_ff         <= S_ACC;
               end else begin
                  state_ff <= S_SHIFT;
               end
            end
            S_ACC: begin
               if (mul_rsp.done) begin
                  if (mul_rsp.ovf) begin
                     ovf_ff   <= 1'b1;
                     state_ff <= S_FINISH;
                  end else begin
                     acc_ff   <= mul_rsp.prod;
                     state_ff <= S_SHIFT;
                  end
               end
            end
            S_SHIFT: begin
               e_ff <= e_shift;
               if (e_shift != '0) begin
                  // square only while higher exponent bits remain
                  mul_req_ff.sgn   <= sgn_ff;
                  mul_req_ff.a     <= cur_ff;
                  mul_req_ff.b     <= cur_ff;
                  state_ff         <= S_SQ;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_SQ: begin
               if (mul_rsp.done) begin
                  if (mul_rsp.ovf) begin
                     ovf_ff   <= 1'b1;
                     state_ff <= S_FINISH;
                  end else begin
                     cur_ff   <= mul_rsp.prod;
                     state_ff <= S_STEP;
                  end
               end
            end
            S_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= ovf_ff ? '0 : (acc_ff & WMASK);
                  rsp_ovf_ff   <= ovf_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

@@ design/cip_checker.sv @@
// ----------------------------------------------------------------------------
// cip_checker
// Port-level checks for the checked integer power block.
// ----------------------------------------------------------------------------
module cip_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata,
   input logic         rsp_tuser
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // an overflowed result reads as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("overflow with nonzero power");

   // block is busy after taking a transaction
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   // reset leaves no response pending
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind checked_integer_power cip_checker u_cip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - checked integer power testbench
// Drives base/exponent/mode transactions into the block, predicts each power
// with an independent square-and-multiply model using 128-bit products for
// the overflow checks, and compares every response in order. Both stream
// sides idle and stall at random across several phases.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned WORD_BITS    = 64;
   localparam int unsigned HALF_PERIOD  = 2;
   localparam int unsigned RESET_CYCLES = 9;
   // Sized from the worst-case time per transaction plus stalls, for ~830
   // transactions, taken several times over.
   localparam longint unsigned LIMIT_CYCLES = 64'd6_000_000;
   localparam int unsigned DRAIN_CYCLES = 1200;
   localparam int unsigned ITEMS_PER_PHASE = 200;
   localparam int unsigned MAX_GAP = 64;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [63:0] power_bits;
      logic        overflow;
   } power_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predict the power of each accepted request, hold it until
   // the matching response arrives, and compare field by field.
   // -------------------------------------------------------------------------
   class power_scoreboard_type;
      power_result_type expected_q[$];
      int unsigned      errors;
      int unsigned      checked;
      logic [63:0]      wmask;
      logic [63:0]      wsign;

      function new();
         errors  = 0;
         checked = 0;
         wmask   = {64{1'b1}} >> (64 - WORD_BITS);
         wsign   = 64'd1 << (WORD_BITS - 1);
      endfunction

      function logic [63:0] widen_signed(input logic [63:0] v);
         logic [63:0] m;
         m = v & wmask;
         return ((m & wsign) != '0) ? (m | ~wmask) : m;
      endfunction

      // One checked multiply in the selected mode; ok drops on overflow.
      function void checked_mul(input logic sgn, input logic [63:0] a,
                                input logic [63:0] b, output logic [63:0] p,
                                output logic ok);
         logic [127:0] wide;
         logic [63:0]  ma;
         logic [63:0]  mb;
         logic [63:0]  limit;
         logic         neg;
         if (sgn == cip_pkg::OP_UNSIGNED) begin
            wide = {64'd0, a} * {64'd0, b};
            ok   = wide <= {64'd0, wmask};
            p    = wide[63:0];
         end else begin
            // compare the magnitude product against the one-sided limit
            neg   = a[63] ^ b[63];
            ma    = a[63] ? -a : a;
            mb    = b[63] ? -b : b;
            limit = neg ? wsign : wsign - 64'd1;
            wide  = {64'd0, ma} * {64'd0, mb};
            ok    = wide <= {64'd0, limit};
            p     = widen_signed(neg ? -wide[63:0] : wide[63:0]);
         end
      endfunction

      // Right-to-left square-and-multiply; square only while bits remain.
      function power_result_type raise_power(input logic op, input logic [63:0] base,
                                             input logic [63:0] expo);
         power_result_type r;
         logic [63:0]      sq;
         logic [63:0]      acc;
         logic [63:0]      e;
         logic             ok;
         logic             ovf;
         sq  = (op == cip_pkg::OP_SIGNED) ? widen_signed(base) : (base & wmask);
         e   = expo;
         acc = 64'd1;
         ovf = 1'b0;
         while (e != 0 && !ovf) begin
            if (e[0]) begin
               checked_mul(op, acc, sq, acc, ok);
               ovf = !ok;
            end
            e = e >> 1;
            if (!ovf && e != 0) begin
               checked_mul(op, sq, sq, sq, ok);
               ovf = !ok;
            end
         end
         r.power_bits = ovf ? 64'd0 : (acc & wmask);
         r.overflow   = ovf;
         return r;
      endfunction

      function void note_request(input logic op, input logic [63:0] base,
                                 input logic [63:0] expo);
         expected_q.push_back(raise_power(op, base, expo));
      endfunction

      function void check_response(input logic [63:0] power_bits, input logic overflow);
         power_result_type exp_r;
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected response %0d: power %h overflow %b",
                        checked, power_bits, overflow);
            return;
         end
         exp_r = expected_q.pop_front();
         if (exp_r.power_bits !== power_bits || exp_r.overflow !== overflow) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("mismatch on response %0d: expected %h/%b, got %h/%b",
                        checked, exp_r.power_bits, exp_r.overflow, power_bits, overflow);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // [63:0] base_bits, [127:64] exponent
   logic         req_tuser = 1'b0; // [0] op
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;        // [63:0] power_bits
   logic         rsp_tuser;        // [0] overflow

   int unsigned          send_idle_pct  = 0;
   int unsigned          recv_stall_pct = 0;
   longint unsigned      cycle_count    = 0;
   power_scoreboard_type sb;

   always #HALF_PERIOD clock = ~clock;

   checked_integer_power #(
      .WORD_BITS(WORD_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Stall the response side at random; change only on the falling edge.
   always @(negedge clock) begin
      if (recv_stall_pct == 0)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check every response transaction at the rising edge it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
   end

   // Hard stop on a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drive tasks: each call starts and ends on a falling edge
   // -------------------------------------------------------------------------
   task automatic send_power(input logic op, input logic [63:0] base,
                             input logic [63:0] expo);
      int unsigned gap;
      gap = 0;
      while (send_idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         // drop valid and idle the request side for the drawn gap
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {expo, base};
      req_tuser  <= op;
      // hold the transaction until the block takes it
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.note_request(op, base, expo);
      @(negedge clock);
   endtask

   // Pause the sender until every expected response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // One random transaction; most are well-formed operands near the
   // overflow boundary, the rest noise, long runs on trivial bases and powers of two.
   task automatic send_random_power();
      int unsigned kind;
      int unsigned k;
      int unsigned e0;
      logic        op;
      logic [63:0] mag;
      logic [63:0] base;
      logic [63:0] expo;
      kind = $urandom_range(99);
      op   = $urandom_range(1) ? cip_pkg::OP_SIGNED : cip_pkg::OP_UNSIGNED;
      if (kind < 20) begin
         // noise: full random operands, sometimes a tiny exponent
         base = {$urandom, $urandom};
         expo = $urandom_range(3) == 0 ? 64'($urandom_range(3)) : {$urandom, $urandom};
      end else if (kind < 80) begin
         // magnitude of k bits, exponent around where the power leaves range
         k    = $urandom_range(64, 1);
         mag  = ({$urandom, $urandom} >> (64 - k)) | (64'd1 << (k - 1));
         base = (op == cip_pkg::OP_SIGNED && $urandom_range(1)) ? -mag : mag;
         e0   = 64 / k;
         expo = 64'($urandom_range(e0 + 2));
      end else if (kind < 90) begin
         // trivial bases walk all exponent bits; unsigned all-ones can overflow early
         case ($urandom_range(2))
            0:       base = 64'd0;
            1:       base = 64'd1;
            default: base = {64{1'b1}};
         endcase
         expo = {$urandom, $urandom};
      end else begin
         // exact powers of two, sign flipped at times in signed mode
         k    = $urandom_range(63);
         mag  = 64'd1 << k;
         base = (op == cip_pkg::OP_SIGNED && $urandom_range(1)) ? -mag : mag;
         e0   = (k == 0) ? 64 : 64 / k;
         expo = 64'($urandom_range(e0 + 1));
      end
      send_power(op, base, expo);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, zero exponent, overflow on the multiply and
      // on the square, and results that land exactly on the range limits.
      send_power(cip_pkg::OP_UNSIGNED, 64'd0, 64'd0);
      send_power(cip_pkg::OP_UNSIGNED, 64'd0, {64{1'b1}});
      send_power(cip_pkg::OP_UNSIGNED, 64'd1, {64{1'b1}});
      send_power(cip_pkg::OP_UNSIGNED, {64{1'b1}}, 64'd0);
      send_power(cip_pkg::OP_UNSIGNED, {64{1'b1}}, 64'd1);
      send_power(cip_pkg::OP_UNSIGNED, {64{1'b1}}, 64'd2);
      send_power(cip_pkg::OP_UNSIGNED, 64'd2, 64'd63);
      send_power(cip_pkg::OP_UNSIGNED, 64'd2, 64'd64);
      send_power(cip_pkg::OP_UNSIGNED, 64'h1_0000_0000, 64'd1);
      send_power(cip_pkg::OP_UNSIGNED, 64'hFFFF_FFFF, 64'd2);
      send_power(cip_pkg::OP_UNSIGNED, 64'd3, 64'd40);
      send_power(cip_pkg::OP_UNSIGNED, 64'd3, 64'd41);
      send_power(cip_pkg::OP_SIGNED, 64'd0, 64'd0);
      send_power(cip_pkg::OP_SIGNED, {64{1'b1}}, {64{1'b1}});
      send_power(cip_pkg::OP_SIGNED, {64{1'b1}}, {{63{1'b1}}, 1'b0});
      send_power(cip_pkg::OP_SIGNED, -64'd2, 64'd63);
      send_power(cip_pkg::OP_SIGNED, 64'd2, 64'd63);
      send_power(cip_pkg::OP_SIGNED, 64'd2, 64'd62);
      send_power(cip_pkg::OP_SIGNED, 64'h8000_0000_0000_0000, 64'd1);
      send_power(cip_pkg::OP_SIGNED, 64'h8000_0000_0000_0000, 64'd2);
      send_power(cip_pkg::OP_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
      send_power(cip_pkg::OP_SIGNED, -64'd3, 64'd39);
      send_power(cip_pkg::OP_SIGNED, -64'd3, 64'd40);
      send_power(cip_pkg::OP_SIGNED, 64'h1_0000_0000, 64'd2);
      wait_drained();

      // Random phases: no idling, sender idle, receiver stalling, both light.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
         endcase
         repeat (ITEMS_PER_PHASE) send_random_power();
         wait_drained();
      end

      // Let any stray response show up before judging.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
